>>> hdl/assert_macros.svh
// Assertion macros used by the top level of the interpolation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of i_clk while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    `ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

>>> hdl/tbi_pkg.sv
// Types and constants shared by the barycentric interpolation pipeline.
package tbi_pkg;

    localparam int IW    = 24;
    localparam int DIFW  = IW + 1;
    localparam int PW    = 2 * DIFW;
    localparam int CW    = PW + 1;
    localparam int SPLIT = 26;
    localparam int PLW   = IW + SPLIT + 1;
    localparam int PHW   = IW + CW - SPLIT;
    localparam int TW    = IW + CW;
    localparam int NW    = TW + 2;
    localparam int DW    = CW;
    localparam int QB    = 33;
    localparam int RW    = DW + QB;
    localparam int QRW   = QB + 1;
    localparam int OW    = 32;

    localparam logic [QRW-1:0] POS_LIM = 34'h0_7FFF_FFFF;
    localparam logic [QRW-1:0] NEG_LIM = 34'h0_8000_0000;

    typedef struct packed {
        logic          neg;
        logic          degen;
        logic          use_ev;
        logic [IW-1:0] ev;
    } t_side;

endpackage

>>> hdl/tbi_rdiv.sv
// Pipelined restoring divider with an overflow check, one quotient bit per stage.
module tbi_rdiv
    import tbi_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  t_side         i_side,
    output logic          o_valid,
    output logic [QB-1:0] o_quot,
    output logic [NW-1:0] o_rem,
    output logic [DW-1:0] o_den,
    output logic          o_ovf,
    output t_side         o_side
);

    logic          r_vld  [0:QB];
    logic [NW-1:0] r_rem  [0:QB];
    logic [QB-1:0] r_q    [0:QB];
    logic [DW-1:0] r_d    [0:QB];
    logic          r_ovf  [0:QB];
    t_side         r_side [0:QB];

    logic n_ovf;

    // A quotient of 2**QB or more saturates in any case.
    assign n_ovf = {{(RW-NW){1'b0}}, i_num} >= {i_den, {QB{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_q[0]    <= '0;
            r_d[0]    <= i_den;
            r_ovf[0]  <= n_ovf;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 1; g <= QB; g++) begin : g_stage
        localparam int BIT = QB - g;

        logic [RW-1:0] trial;
        logic          ge;
        logic [NW-1:0] n_rem;
        logic [QB-1:0] n_q;

        assign trial = {{(RW-DW){1'b0}}, r_d[g-1]} << BIT;
        assign ge    = {{(RW-NW){1'b0}}, r_rem[g-1]} >= trial;
        assign n_rem = ge ? (r_rem[g-1] - trial[NW-1:0]) : r_rem[g-1];
        assign n_q   = r_q[g-1] | (QB'(ge) << BIT);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= r_vld[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_q[g]    <= n_q;
                r_d[g]    <= r_d[g-1];
                r_ovf[g]  <= r_ovf[g-1];
                r_side[g] <= r_side[g-1];
            end
        end
    end

    assign o_valid = r_vld[QB];
    assign o_quot  = r_q[QB];
    assign o_rem   = r_rem[QB];
    assign o_den   = r_d[QB];
    assign o_ovf   = r_ovf[QB];
    assign o_side  = r_side[QB];

endmodule

>>> hdl/triangle_barycentric_interpolate.sv
// Top level of the barycentric triangle interpolation pipeline.
// Throughput: one beat per cycle while the skid stage is empty; the 33-stage divider fixes the depth.
// An output register and a one-beat skid stage let the input keep flowing.
// Reset clears all valid bits and the override register; data is not reset.
module triangle_barycentric_interpolate
    import tbi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [IW-1:0] i_v0_x,
    input  logic signed [IW-1:0] i_v0_y,
    input  logic signed [IW-1:0] i_v1_x,
    input  logic signed [IW-1:0] i_v1_y,
    input  logic signed [IW-1:0] i_v2_x,
    input  logic signed [IW-1:0] i_v2_y,
    input  logic signed [IW-1:0] i_v0_value,
    input  logic signed [IW-1:0] i_v1_value,
    input  logic signed [IW-1:0] i_v2_value,
    input  logic signed [IW-1:0] i_query_x,
    input  logic signed [IW-1:0] i_query_y,
    input  logic signed [IW-1:0] i_element_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [OW-1:0] o_result_value,
    output logic                 o_degenerate
);

    `include "assert_macros.svh"

    function automatic logic signed [DIFW-1:0] dif(input logic [IW-1:0] a,
                                                    input logic [IW-1:0] b);
        return {a[IW-1], a} - {b[IW-1], b};
    endfunction

    function automatic logic signed [CW-1:0] xsub(input logic [PW-1:0] a,
                                                   input logic [PW-1:0] b);
        return {a[PW-1], a} - {b[PW-1], b};
    endfunction

    logic r_use;
    logic adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use <= 1'b0;
        end else if (i_cfg_we) begin
            r_use <= i_cfg_wdata;
        end
    end

    logic r_skid_v;
    assign adv        = !r_skid_v;
    assign o_in_stall = r_skid_v;

    // Stage registers.
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v;
    logic r_r_v, r_a_v, r_f_v;

    logic signed [DIFW-1:0] r_ax1, r_ax2, r_ay1, r_ay2;
    logic signed [DIFW-1:0] r_dx0, r_dx1, r_dx2, r_dy0, r_dy1, r_dy2;
    logic signed [IW-1:0]   r_s1_c0, r_s1_c1, r_s1_c2;
    t_side                  r_s1_side;

    logic signed [PW-1:0]   r_pa0, r_pa1, r_ph0, r_ph1, r_pr0, r_pr1, r_ps0, r_ps1;
    logic signed [IW-1:0]   r_s2_c0, r_s2_c1, r_s2_c2;
    t_side                  r_s2_side;

    logic signed [CW-1:0]   r_s3_area, r_nh, r_nr, r_ns;
    logic signed [IW-1:0]   r_s3_c0, r_s3_c1, r_s3_c2;
    t_side                  r_s3_side;

    logic signed [PLW-1:0]  r_l0, r_l1, r_l2;
    logic signed [PHW-1:0]  r_h0, r_h1, r_h2;
    logic signed [CW-1:0]   r_s4_area;
    t_side                  r_s4_side;

    logic signed [TW-1:0]   r_t0, r_t1, r_t2;
    logic signed [CW-1:0]   r_s5_area;
    t_side                  r_s5_side;

    logic signed [NW-1:0]   r_sum;
    logic signed [CW-1:0]   r_s6_area;
    t_side                  r_s6_side;

    logic [NW-1:0]          r_s7_num;
    logic [DW-1:0]          r_s7_den;
    t_side                  r_s7_side;

    logic          div_v;
    logic [QB-1:0] div_q;
    logic [NW-1:0] div_rem;
    logic [DW-1:0] div_den;
    logic          div_ovf;
    t_side         div_side;

    logic [QB-1:0]  r_r_q;
    logic           r_r_rnd;
    logic           r_r_ovf;
    t_side          r_r_side;

    logic [QRW-1:0] r_a_qr;
    logic           r_a_ovf;
    t_side          r_a_side;

    logic [OW-1:0]  r_f_res;
    logic           r_f_deg;

    logic [OW-1:0]  r_out_res, r_skid_res;
    logic           r_out_deg, r_skid_deg, r_out_v;

    t_side         n_s1_side, n_s4_side, n_s7_side;
    logic [QRW-1:0] n_lim;
    logic           n_sat;
    logic [OW-1:0]  n_mag, n_val, n_f_res;
    logic           n_f_deg;
    logic           out_free;

    always_comb begin
        n_s1_side        = '0;
        n_s1_side.use_ev = r_use;
        n_s1_side.ev     = i_element_value;

        n_s4_side        = r_s3_side;
        n_s4_side.degen  = (r_s3_area == '0);

        n_s7_side        = r_s6_side;
        n_s7_side.neg    = r_sum[NW-1] ^ r_s6_area[CW-1];
    end

    // Valid bits advance together while the skid stage is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_r_v  <= 1'b0;
            r_a_v  <= 1'b0;
            r_f_v  <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_r_v  <= div_v;
            r_a_v  <= r_r_v;
            r_f_v  <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax1     <= dif(i_v1_x, i_v0_x);
            r_ax2     <= dif(i_v2_x, i_v0_x);
            r_ay1     <= dif(i_v1_y, i_v0_y);
            r_ay2     <= dif(i_v2_y, i_v0_y);
            r_dx0     <= dif(i_v0_x, i_query_x);
            r_dx1     <= dif(i_v1_x, i_query_x);
            r_dx2     <= dif(i_v2_x, i_query_x);
            r_dy0     <= dif(i_v0_y, i_query_y);
            r_dy1     <= dif(i_v1_y, i_query_y);
            r_dy2     <= dif(i_v2_y, i_query_y);
            r_s1_c0   <= i_v0_value;
            r_s1_c1   <= i_v1_value;
            r_s1_c2   <= i_v2_value;
            r_s1_side <= n_s1_side;

            r_pa0     <= r_ax1 * r_ay2;
            r_pa1     <= r_ax2 * r_ay1;
            r_ph0     <= r_dx1 * r_dy2;
            r_ph1     <= r_dx2 * r_dy1;
            r_pr0     <= r_dx2 * r_dy0;
            r_pr1     <= r_dx0 * r_dy2;
            r_ps0     <= r_dx0 * r_dy1;
            r_ps1     <= r_dx1 * r_dy0;
            r_s2_c0   <= r_s1_c0;
            r_s2_c1   <= r_s1_c1;
            r_s2_c2   <= r_s1_c2;
            r_s2_side <= r_s1_side;

            r_s3_area <= xsub(r_pa0, r_pa1);
            r_nh      <= xsub(r_ph0, r_ph1);
            r_nr      <= xsub(r_pr0, r_pr1);
            r_ns      <= xsub(r_ps0, r_ps1);
            r_s3_c0   <= r_s2_c0;
            r_s3_c1   <= r_s2_c1;
            r_s3_c2   <= r_s2_c2;
            r_s3_side <= r_s2_side;

            // Each weight is split into a signed high part and an unsigned low part.
            r_l0      <= r_s3_c0 * $signed({1'b0, r_nh[SPLIT-1:0]});
            r_h0      <= r_s3_c0 * $signed(r_nh[CW-1:SPLIT]);
            r_l1      <= r_s3_c1 * $signed({1'b0, r_nr[SPLIT-1:0]});
            r_h1      <= r_s3_c1 * $signed(r_nr[CW-1:SPLIT]);
            r_l2      <= r_s3_c2 * $signed({1'b0, r_ns[SPLIT-1:0]});
            r_h2      <= r_s3_c2 * $signed(r_ns[CW-1:SPLIT]);
            r_s4_area <= r_s3_area;
            r_s4_side <= n_s4_side;

            r_t0      <= {r_h0, {SPLIT{1'b0}}} + {{(TW-PLW){r_l0[PLW-1]}}, r_l0};
            r_t1      <= {r_h1, {SPLIT{1'b0}}} + {{(TW-PLW){r_l1[PLW-1]}}, r_l1};
            r_t2      <= {r_h2, {SPLIT{1'b0}}} + {{(TW-PLW){r_l2[PLW-1]}}, r_l2};
            r_s5_area <= r_s4_area;
            r_s5_side <= r_s4_side;

            r_sum     <= {{(NW-TW){r_t0[TW-1]}}, r_t0} + {{(NW-TW){r_t1[TW-1]}}, r_t1}
                       + {{(NW-TW){r_t2[TW-1]}}, r_t2};
            r_s6_area <= r_s5_area;
            r_s6_side <= r_s5_side;

            r_s7_num  <= r_sum[NW-1] ? (NW'(0) - r_sum) : r_sum;
            r_s7_den  <= r_s6_area[CW-1] ? (DW'(0) - r_s6_area) : r_s6_area;
            r_s7_side <= n_s7_side;
        end
    end

    tbi_rdiv u_rdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_s7_v),
        .i_num   (r_s7_num),
        .i_den   (r_s7_den),
        .i_side  (r_s7_side),
        .o_valid (div_v),
        .o_quot  (div_q),
        .o_rem   (div_rem),
        .o_den   (div_den),
        .o_ovf   (div_ovf),
        .o_side  (div_side)
    );

    always_comb begin
        n_lim = r_a_side.neg ? NEG_LIM : POS_LIM;
        n_sat = r_a_ovf || (r_a_qr > n_lim);
        n_mag = n_sat ? n_lim[OW-1:0] : r_a_qr[OW-1:0];
        n_val = r_a_side.neg ? (OW'(0) - n_mag) : n_mag;
        if (r_a_side.use_ev) begin
            n_f_res = {{(OW-IW){r_a_side.ev[IW-1]}}, r_a_side.ev};
            n_f_deg = 1'b0;
        end else if (r_a_side.degen) begin
            n_f_res = '0;
            n_f_deg = 1'b1;
        end else begin
            n_f_res = n_val;
            n_f_deg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_r_q    <= div_q;
            r_r_rnd  <= {div_rem, 1'b0} >= {{(NW+1-DW){1'b0}}, div_den};
            r_r_ovf  <= div_ovf;
            r_r_side <= div_side;

            r_a_qr   <= {1'b0, r_r_q} + QRW'(r_r_rnd);
            r_a_ovf  <= r_r_ovf;
            r_a_side <= r_r_side;

            r_f_res  <= n_f_res;
            r_f_deg  <= n_f_deg;
        end
    end

    // Output register with a one-beat skid stage behind it.
    assign out_free = !r_out_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= r_f_v;
            end
        end else if (r_f_v && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_res <= r_skid_v ? r_skid_res : r_f_res;
            r_out_deg <= r_skid_v ? r_skid_deg : r_f_deg;
        end else if (!r_skid_v) begin
            r_skid_res <= r_f_res;
            r_skid_deg <= r_f_deg;
        end
    end

    assign o_out_valid    = r_out_v;
    assign o_result_value = r_out_res;
    assign o_degenerate   = r_out_deg;

    `ASSERT_CLK(a_skid_behind_out, r_skid_v |-> r_out_v, "skid stage full while output empty")
    `ASSERT_CLK(a_degen_zero, (r_out_v && r_out_deg) |-> (r_out_res == '0),
        "degenerate beat with a nonzero result")
    `ASSERT_NEXT(a_skid_catch, (!r_skid_v && r_out_v && i_out_stall && r_f_v), r_skid_v,
        "finished beat not caught by the skid stage")

endmodule
